FILE: hdl/mrp_pkg.sv
// shared types and constants of the monitor request parser
// no dependencies; imported by every module of the parser

package mrp_pkg;

	// default capacity of the argument length store
	localparam int MAX_ARGS_DEF = 16;

	// parse phases, as shown on the phase output
	typedef enum logic [2:0] {
		PH_VERSION = 3'd0,
		PH_COMMAND = 3'd1,
		PH_COUNT   = 3'd2,
		PH_LENGTHS = 3'd3,
		PH_DATA    = 3'd4,
		PH_DONE    = 3'd5,
		PH_ERROR   = 3'd6
	} phase_t;

	// register indexes on the config port (word address)
	localparam logic [1:0] REG_VERSION   = 2'd0;
	localparam logic [1:0] REG_COUNT_LIM = 2'd1;
	localparam logic [1:0] REG_LEN_LIM   = 2'd2;

	// reset values of the config registers
	localparam logic [7:0] VERSION_RST   = 8'd1;
	localparam logic [4:0] COUNT_LIM_RST = 5'd16;
	localparam logic [7:0] LEN_LIM_RST   = 8'd255;

	typedef struct packed {
		logic [7:0] version;
		logic [4:0] count_lim;
		logic [7:0] len_lim;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic skip_chk;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip_req;
		logic skip_more;
	} dp_stat_t;

endpackage

FILE: hdl/monitor_request_parser_core.sv
// top level of the monitor request parser
// depends on mrp_pkg, mrp_apb, mrp_ctrl, mrp_dp
//
// channel   | handshake           | payload
// ----------+---------------------+-------------------------------------------
// request   | in_valid/in_ready   | data_byte
// result    | out_valid/out_ready | phase command arg_count byte_valid
//           |                     | arg_index arg_offset arg_byte arg_end
//           |                     | finished errored
// config    | psel/penable/pwrite | paddr pwdata prdata pready (apb, no waits)
//
// a request is accepted and decoded, then loaded into the result register
// in the emit step; after the last length byte or the last byte of an
// argument the length store is walked first, each entry visited taking a
// registered read, then a check
// reset clears the phase and capture registers; the length store holds no
// reset value and is only read after the length phase has written it
// a waiting result does not block the next request; a new result waits
// in the emit step until the result register is free

module monitor_request_parser_core #(
	parameter int MAX_ARGS = mrp_pkg::MAX_ARGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  phase,
	output logic [7:0]  command,
	output logic [4:0]  arg_count,
	output logic        byte_valid,
	output logic [3:0]  arg_index,
	output logic [7:0]  arg_offset,
	output logic [7:0]  arg_byte,
	output logic        arg_end,
	output logic        finished,
	output logic        errored
);
	import mrp_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// config registers
	mrp_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencing: accept, empty-argument walk, result hand-off
	mrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// parse state, length store and result register
	mrp_dp #(
		.MAX_ARGS (MAX_ARGS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.stat       (stat),
		.data_byte  (data_byte),
		.phase      (phase),
		.command    (command),
		.arg_count  (arg_count),
		.byte_valid (byte_valid),
		.arg_index  (arg_index),
		.arg_offset (arg_offset),
		.arg_byte   (arg_byte),
		.arg_end    (arg_end),
		.finished   (finished),
		.errored    (errored)
	);

endmodule

FILE: hdl/mrp_apb.sv
// config register file with apb-style write/read access
// depends on mrp_pkg

module mrp_apb (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output mrp_pkg::cfg_t cfg
);
	import mrp_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version   <= VERSION_RST;
			cfg_q.count_lim <= COUNT_LIM_RST;
			cfg_q.len_lim   <= LEN_LIM_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_VERSION:   cfg_q.version   <= pwdata[7:0];
				REG_COUNT_LIM: cfg_q.count_lim <= pwdata[4:0];
				REG_LEN_LIM:   cfg_q.len_lim   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_VERSION:   prdata = {24'd0, cfg_q.version};
			REG_COUNT_LIM: prdata = {27'd0, cfg_q.count_lim};
			REG_LEN_LIM:   prdata = {24'd0, cfg_q.len_lim};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

FILE: hdl/mrp_ctrl.sv
// sequencing controller: request handshake, empty-argument walk, result hand-off
// depends on mrp_pkg

module mrp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mrp_pkg::dp_stat_t  stat,
	output mrp_pkg::dp_cmd_t   cmd
);
	import mrp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SK_RD,
		ST_SK_CHK,
		ST_EMIT
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic        out_valid_q;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign cmd.accept   = in_valid & (state_q == ST_IDLE);
	assign cmd.skip_chk = (state_q == ST_SK_CHK);
	assign cmd.load_out = (state_q == ST_EMIT) & (~out_valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= stat.skip_req ? ST_SK_RD : ST_EMIT;
					end
				end
				ST_SK_RD: begin
					state_q <= ST_SK_CHK;
				end
				ST_SK_CHK: begin
					state_q <= stat.skip_more ? ST_SK_RD : ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/mrp_dp.sv
// parser datapath: phase and capture registers, length store, result register
// depends on mrp_pkg

module mrp_dp #(
	parameter int MAX_ARGS = mrp_pkg::MAX_ARGS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mrp_pkg::cfg_t     cfg,
	input  mrp_pkg::dp_cmd_t  cmd,
	output mrp_pkg::dp_stat_t stat,
	input  logic [7:0]        data_byte,
	output logic [2:0]        phase,
	output logic [7:0]        command,
	output logic [4:0]        arg_count,
	output logic              byte_valid,
	output logic [3:0]        arg_index,
	output logic [7:0]        arg_offset,
	output logic [7:0]        arg_byte,
	output logic              arg_end,
	output logic              finished,
	output logic              errored
);
	import mrp_pkg::*;

	localparam int CW = $clog2(MAX_ARGS + 1);
	localparam int AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

	// parse state
	phase_t        phase_q;
	logic [7:0]    command_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [7:0]    off_q;
	logic [7:0]    cur_len_q;

	// length store
	logic [7:0]    len_mem [MAX_ARGS];
	logic [7:0]    rd_q;

	// per-request result fields, held until the result is loaded
	logic          pend_valid_q;
	logic [3:0]    pend_idx_q;
	logic [7:0]    pend_off_q;
	logic [7:0]    pend_byte_q;
	logic          pend_end_q;

	// next-state logic for an accepted byte
	phase_t        phase_d;
	logic [CW-1:0] count_d;
	logic [CW-1:0] idx_d;
	logic [7:0]    off_d;
	logic          mem_we;
	logic          data_hit;
	logic          data_end;
	logic          skip_req;
	logic [8:0]    count_cap;
	logic [8:0]    off_inc;
	logic [CW-1:0] idx_inc;
	logic [CW+3:0] idx_ext;
	logic [CW+4:0] count_ext;

	assign idx_inc   = idx_q + CW'(1);
	assign off_inc   = {1'b0, off_q} + 9'd1;
	assign idx_ext   = {4'd0, idx_q};
	assign count_ext = {5'd0, count_q};
	assign count_cap = (9'(cfg.count_lim) > 9'(MAX_ARGS)) ? 9'(MAX_ARGS) : 9'(cfg.count_lim);

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		idx_d    = idx_q;
		off_d    = off_q;
		mem_we   = 1'b0;
		data_hit = 1'b0;
		data_end = 1'b0;
		skip_req = 1'b0;
		case (phase_q)
			PH_VERSION: begin
				phase_d = (data_byte == cfg.version) ? PH_COMMAND : PH_ERROR;
			end
			PH_COMMAND: begin
				phase_d = PH_COUNT;
			end
			PH_COUNT: begin
				if ({1'b0, data_byte} > count_cap) begin
					phase_d = PH_ERROR;
				end else begin
					count_d = data_byte[CW-1:0];
					idx_d   = '0;
					phase_d = (data_byte == 8'd0) ? PH_DONE : PH_LENGTHS;
				end
			end
			PH_LENGTHS: begin
				if (data_byte > cfg.len_lim) begin
					phase_d = PH_ERROR;
				end else begin
					mem_we = 1'b1;
					if (idx_inc >= count_q) begin
						idx_d    = '0;
						off_d    = 8'd0;
						skip_req = 1'b1;
					end else begin
						idx_d = idx_inc;
					end
				end
			end
			PH_DATA: begin
				data_hit = 1'b1;
				if (off_inc >= {1'b0, cur_len_q}) begin
					data_end = 1'b1;
					idx_d    = idx_inc;
					off_d    = 8'd0;
					skip_req = 1'b1;
				end else begin
					off_d = off_inc[7:0];
				end
			end
			default: ;
		endcase
	end

	assign stat.skip_req  = skip_req;
	assign stat.skip_more = (idx_q < count_q) && (rd_q == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_VERSION;
			command_q <= 8'd0;
			count_q   <= '0;
			idx_q     <= '0;
			off_q     <= 8'd0;
		end else if (cmd.accept) begin
			phase_q <= phase_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			off_q   <= off_d;
			if (phase_q == PH_COMMAND) begin
				command_q <= data_byte;
			end
		end else if (cmd.skip_chk) begin
			// walk past empty arguments, one store entry per check
			if (idx_q >= count_q) begin
				phase_q <= PH_DONE;
			end else if (rd_q == 8'd0) begin
				idx_q <= idx_inc;
			end else begin
				phase_q <= PH_DATA;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_valid_q <= data_hit;
			pend_idx_q   <= data_hit ? idx_ext[3:0] : 4'd0;
			pend_off_q   <= data_hit ? off_q : 8'd0;
			pend_byte_q  <= data_hit ? data_byte : 8'd0;
			pend_end_q   <= data_end;
		end
		if (cmd.skip_chk && (idx_q < count_q) && (rd_q != 8'd0)) begin
			cur_len_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && mem_we) begin
			len_mem[idx_q[AW-1:0]] <= data_byte;
		end
		rd_q <= len_mem[idx_q[AW-1:0]];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			phase      <= phase_q;
			command    <= command_q;
			arg_count  <= count_ext[4:0];
			byte_valid <= pend_valid_q;
			arg_index  <= pend_idx_q;
			arg_offset <= pend_off_q;
			arg_byte   <= pend_byte_q;
			arg_end    <= pend_end_q;
			finished   <= (phase_q == PH_DONE) || (phase_q == PH_ERROR);
			errored    <= (phase_q == PH_ERROR);
		end
	end

endmodule

FILE: hdl/mrp_checker.sv
// port-level checks of the monitor request parser, bound to the top level
// depends on mrp_pkg and monitor_request_parser_core

module mrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  phase,
	input logic [7:0]  command,
	input logic [4:0]  arg_count,
	input logic        byte_valid,
	input logic [3:0]  arg_index,
	input logic [7:0]  arg_offset,
	input logic [7:0]  arg_byte,
	input logic        arg_end,
	input logic        finished,
	input logic        errored
);
	import mrp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(arg_byte)
		&& $stable(byte_valid) && $stable(arg_offset))
		else $error("result changed while stalled");

	// flags agree with the phase
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (finished == ((phase == PH_DONE) || (phase == PH_ERROR)))
		&& (errored == (phase == PH_ERROR)))
		else $error("finished/errored disagree with phase");

	// non-data results carry zero data fields
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> arg_index == 4'd0 && arg_offset == 8'd0
		&& arg_byte == 8'd0 && !arg_end)
		else $error("data fields set on a non-data result");

	// a data byte is only seen in the data phase or as the one that finishes it
	a_data_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> (phase == PH_DATA) || (arg_end && phase == PH_DONE))
		else $error("data byte outside the data phase");

	// the error phase never leaves once shown
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && errored && in_valid && in_ready ##2
		out_valid |-> errored)
		else $error("error phase left");

endmodule

bind monitor_request_parser_core mrp_checker u_mrp_checker (.*);
